// File: hdl/integer_to_text_formatter_unit_defines.svh
// assertion macros used by the checker file
`ifndef INTEGER_TO_TEXT_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ITF_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("formatter check failed");

// antecedent implies consequent in the next cycle
`define ITF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("formatter check failed");

`endif

// File: hdl/itf_pkg.sv
// shared types, codes and character tables of the integer to text formatter
package itf_pkg;

    localparam int WORK_W   = 72;
    localparam int CNT_W    = 5;

    // specifier characters
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_PCT  = 8'h25;

    // fixed output characters
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_L     = 8'h6c;

    // digit counts and iteration counts
    localparam logic [CNT_W-1:0] DABBLE_LAST = 5'd31;
    localparam logic [CNT_W-1:0] DEC_DIGITS  = 5'd10;
    localparam logic [CNT_W-1:0] HEX32_DIGITS = 5'd8;
    localparam logic [CNT_W-1:0] HEX64_DIGITS = 5'd16;

    // work unit operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_DABBLE = 2'd2;
    localparam logic [1:0] OP_NIBBLE = 2'd3;

    // fixed text kinds
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_LIT   = 3'd1;
    localparam logic [2:0] K_MINUS = 3'd2;
    localparam logic [2:0] K_HEX0X = 3'd3;
    localparam logic [2:0] K_NIL   = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [WORK_W-1:0] data;
    } t_unit_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] char_out;
        logic       last;
    } t_emit;

    // ascii of one digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'd0, nib};
        end else if (upper) begin
            ch = 8'h37 + {4'd0, nib};
        end else begin
            ch = 8'h57 + {4'd0, nib};
        end
        return ch;
    endfunction

    // length of each fixed text
    function automatic logic [2:0] fix_len(input logic [2:0] kind);
        logic [2:0] len;
        case (kind)
            K_HEX0X: len = 3'd2;
            K_NIL:   len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    // one character of a fixed text
    function automatic logic [7:0] fix_char(input logic [2:0] kind, input logic [2:0] idx,
                                            input logic [7:0] lit);
        logic [7:0] ch;
        case (kind)
            K_MINUS: ch = CH_MINUS;
            K_HEX0X: ch = (idx == 3'd0) ? CH_ZERO : CH_LX;
            K_NIL: begin
                case (idx)
                    3'd0:    ch = CH_LPAR;
                    3'd1:    ch = CH_N;
                    3'd2:    ch = CH_I;
                    3'd3:    ch = CH_L;
                    default: ch = CH_RPAR;
                endcase
            end
            default: ch = lit;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/itf_digit_unit.sv
// shared digit register: load, double dabble step and nibble shift over one work word
module itf_digit_unit (
    input  logic                 i_clk,
    input  itf_pkg::t_unit_ctl   i_ctl,
    output logic [3:0]           o_top
);
    import itf_pkg::*;

    logic [WORK_W-1:0] r_work;
    logic [WORK_W-1:0] n_work;
    logic [WORK_W-1:0] adj;

    // add three to every bcd digit of five or more
    always_comb begin
        adj = r_work;
        for (int k = 0; k < 10; k++) begin
            if (r_work[32 + 4*k +: 4] >= 4'd5) begin
                adj[32 + 4*k +: 4] = r_work[32 + 4*k +: 4] + 4'd3;
            end
        end
    end

    // operation select
    always_comb begin
        case (i_ctl.op)
            OP_LOAD:   n_work = i_ctl.data;
            OP_DABBLE: n_work = {adj[WORK_W-2:0], 1'b0};
            OP_NIBBLE: n_work = {r_work[WORK_W-5:0], 4'd0};
            default:   n_work = r_work;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_top = r_work[WORK_W-1 -: 4];

endmodule

// File: hdl/itf_seq.sv
// sequencer: decodes the specifier, steps the digit unit, emits characters
module itf_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_action,
    input  logic [7:0]          i_spec,
    input  logic [63:0]         i_value,
    input  logic                i_can_emit,
    input  logic [3:0]          i_top,
    output logic                o_ready,
    output itf_pkg::t_unit_ctl  o_ctl,
    output itf_pkg::t_emit      o_emit
);
    import itf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_SKIP = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_kind, n_kind;
    logic [7:0]       r_lit, n_lit;
    logic [2:0]       r_idx, n_idx;
    logic             r_has_dig, n_has_dig;
    logic             r_upper, n_upper;

    logic [31:0] low32;
    logic [31:0] mag;
    logic [2:0]  len;

    assign low32 = i_value[31:0];
    assign mag   = (low32[31] && (i_spec != CH_U)) ? (~low32 + 32'd1) : low32;
    assign len   = fix_len(r_kind);

    // next state and unit control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_kind    = r_kind;
        n_lit     = r_lit;
        n_idx     = r_idx;
        n_has_dig = r_has_dig;
        n_upper   = r_upper;
        o_ctl.op   = OP_HOLD;
        o_ctl.data = '0;
        o_emit.valid    = 1'b0;
        o_emit.char_out = '0;
        o_emit.last     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx     = '0;
                    n_has_dig = 1'b0;
                    n_upper   = 1'b0;
                    n_lit     = i_spec;
                    n_kind    = K_LIT;
                    o_ctl.data = {40'd0, mag};
                    if (!i_action) begin
                        n_state = S_FIX;
                    end else begin
                        case (i_spec)
                            CH_C: begin
                                n_lit   = i_value[7:0];
                                n_state = S_FIX;
                            end
                            CH_PCT: n_state = S_FIX;
                            CH_D, CH_I, CH_U: begin
                                n_kind    = (low32[31] && (i_spec != CH_U)) ? K_MINUS : K_NONE;
                                o_ctl.op  = OP_LOAD;
                                n_cnt     = DABBLE_LAST;
                                n_has_dig = 1'b1;
                                n_state   = S_CONV;
                            end
                            CH_LX, CH_UX: begin
                                n_kind     = K_NONE;
                                o_ctl.op   = OP_LOAD;
                                o_ctl.data = {low32, 40'd0};
                                n_cnt      = HEX32_DIGITS;
                                n_upper    = (i_spec == CH_UX);
                                n_has_dig  = 1'b1;
                                n_state    = S_SKIP;
                            end
                            CH_P: begin
                                if (i_value == 64'd0) begin
                                    n_kind = K_NIL;
                                end else begin
                                    n_kind     = K_HEX0X;
                                    o_ctl.op   = OP_LOAD;
                                    o_ctl.data = {i_value, 8'd0};
                                    n_cnt      = HEX64_DIGITS;
                                    n_has_dig  = 1'b1;
                                end
                                n_state = S_FIX;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
            // binary to bcd, one bit per cycle
            S_CONV: begin
                o_ctl.op = OP_DABBLE;
                if (r_cnt == '0) begin
                    n_cnt   = DEC_DIGITS;
                    n_state = (r_kind == K_NONE) ? S_SKIP : S_FIX;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            // fixed text, alone or ahead of the digits
            S_FIX: begin
                if (i_can_emit) begin
                    o_emit.valid    = 1'b1;
                    o_emit.char_out = fix_char(r_kind, r_idx, r_lit);
                    o_emit.last     = (r_idx == len - 3'd1) && !r_has_dig;
                    if (r_idx == len - 3'd1) begin
                        n_state = r_has_dig ? S_SKIP : S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            // drop leading zeros, keep at least one digit
            S_SKIP: begin
                if ((r_cnt > 5'd1) && (i_top == 4'd0)) begin
                    o_ctl.op = OP_NIBBLE;
                    n_cnt    = r_cnt - 5'd1;
                end else begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (i_can_emit) begin
                    o_emit.valid    = 1'b1;
                    o_emit.char_out = hex_char(i_top, r_upper);
                    o_emit.last     = (r_cnt == 5'd1);
                    o_ctl.op        = OP_NIBBLE;
                    n_cnt           = r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_kind    <= K_NONE;
            r_idx     <= '0;
            r_has_dig <= 1'b0;
            r_upper   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_kind    <= n_kind;
            r_idx     <= n_idx;
            r_has_dig <= n_has_dig;
            r_upper   <= n_upper;
        end
    end

    // literal byte needs no reset
    always_ff @(posedge i_clk) begin
        r_lit <= n_lit;
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// File: hdl/integer_to_text_formatter_unit.sv
// For a literal, c, % and p the fixed text state emits the first character, which the output
// register takes when free; the block stays busy until its last character is registered.
// Decimal d, i, u: double dabble steps, a minus sign when negative, a step to end the zero skip,
// then the skipped zeros and the digits.
// Hex x, X: skipped zeros then digits; p: the 0x prefix then the hex digits, or (nil) for zero.
// A new transaction is accepted only while idle, after the previous one's last character.
// Reset is synchronous, active low; it clears the sequencer and the output valid.
module integer_to_text_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_spec,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char_out,
    output logic        o_last
);
    import itf_pkg::*;

    t_unit_ctl  ctl;
    t_emit      emit;
    logic [3:0] top;
    logic       can_emit;

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;

    assign can_emit = !r_valid || i_ready;

    itf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_action   (i_action),
        .i_spec     (i_spec),
        .i_value    (i_value),
        .i_can_emit (can_emit),
        .i_top      (top),
        .o_ready    (o_ready),
        .o_ctl      (ctl),
        .o_emit     (emit)
    );

    itf_digit_unit u_digit (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .o_top (top)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_char <= emit.char_out;
            r_last <= emit.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

endmodule

// File: hdl/itf_checker.sv
// port level checks of the formatter, bound to the top level
`include "integer_to_text_formatter_unit_defines.svh"

module itf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_action,
    input logic [7:0]  i_spec,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_char_out,
    input logic        o_last
);
    import itf_pkg::*;

    // stalled character holds
    `ITF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_char_out) && $stable(o_last))

    // busy while a transaction still has characters to send
    `ITF_ASSERT_SAME(a_busy_mid, i_clk, i_rst_n, o_valid && !o_last, !o_ready)

    // a literal makes the block busy
    `ITF_ASSERT_NEXT(a_lit_busy, i_clk, i_rst_n, i_valid && o_ready && !i_action, !o_ready)

    // a literal reaches the output through the fixed text state and the output register when the output is free
    `ITF_ASSERT_NEXT(a_lit_out, i_clk, i_rst_n, i_valid && o_ready && !i_action && (!o_valid || i_ready), ##1 (o_valid && o_last && (o_char_out == $past(i_spec, 2))))

endmodule

bind integer_to_text_formatter_unit itf_checker u_itf_checker (.*);

// File: verif/tb.sv
// self-checking testbench for the integer to text formatter unit
module tb;
    import itf_pkg::*;

    // run limit in time units, several times the slowest legal run
    localparam int RUN_LIMIT   = 4000000;
    localparam int DRAIN_WAIT  = 80;
    localparam int RAND_ITEMS  = 156;

    // specifier that the block does not know
    localparam logic [7:0] SPEC_STRING = 8'h73;

    // digit tables, index 0 in the top byte
    localparam logic [8*16-1:0] DIGITS_LOWER = "0123456789abcdef";
    localparam logic [8*16-1:0] DIGITS_UPPER = "0123456789ABCDEF";

    typedef struct {
        logic        action;
        logic [7:0]  spec;
        logic [63:0] value;
    } t_fmt_request;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [7:0]  i_spec = 8'd0;
    logic [63:0] i_value = 64'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_char_out;
    logic        o_last;

    t_fmt_request pending_requests[$];
    t_text_char   expected_chars[$];

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   in_wait = 0;
    int   out_wait = 0;
    int   in_max_gap = 15;
    int   out_max_stall = 15;
    int   mismatch_count = 0;

    integer_to_text_formatter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_spec     (i_spec),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // one expected character, not yet last
    task automatic push_char(input logic [7:0] ch);
        t_text_char e;
        e.ch = ch;
        e.last = 1'b0;
        expected_chars.push_back(e);
    endtask

    // digits of v, most significant first
    task automatic push_number(input logic [63:0] v, input int unsigned radix,
                               input logic upper);
        logic [7:0] digs [0:19];
        int len;
        int idx;
        len = 0;
        if (v == 64'd0) begin
            push_char(CH_ZERO);
        end else begin
            while (v != 64'd0) begin
                idx = int'(v % radix);
                digs[len] = upper ? DIGITS_UPPER[8*(15-idx) +: 8]
                                  : DIGITS_LOWER[8*(15-idx) +: 8];
                len++;
                v = v / radix;
            end
            while (len > 0) begin
                len--;
                push_char(digs[len]);
            end
        end
    endtask

    // expected text of one accepted transaction
    task automatic predict_text(input logic action, input logic [7:0] spec,
                                input logic [63:0] value);
        int start;
        logic [31:0] low32;
        start = expected_chars.size();
        low32 = value[31:0];
        if (!action) begin
            push_char(spec);
        end else begin
            case (spec)
                CH_C: push_char(value[7:0]);
                CH_D, CH_I: begin
                    if (low32[31]) begin
                        push_char(CH_MINUS);
                        push_number({32'd0, (~low32) + 32'd1}, 10, 1'b0);
                    end else begin
                        push_number({32'd0, low32}, 10, 1'b0);
                    end
                end
                CH_U:  push_number({32'd0, low32}, 10, 1'b0);
                CH_LX: push_number({32'd0, low32}, 16, 1'b0);
                CH_UX: push_number({32'd0, low32}, 16, 1'b1);
                CH_P: begin
                    if (value == 64'd0) begin
                        push_char(CH_LPAR);
                        push_char(CH_N);
                        push_char(CH_I);
                        push_char(CH_L);
                        push_char(CH_RPAR);
                    end else begin
                        push_char(CH_ZERO);
                        push_char(CH_LX);
                        push_number(value, 16, 1'b0);
                    end
                end
                CH_PCT: push_char(CH_PCT);
                default: ;
            endcase
        end
        if (expected_chars.size() > start) begin
            expected_chars[expected_chars.size()-1].last = 1'b1;
        end
    endtask

    // request driver, changes inputs on the falling edge
    always @(negedge i_clk) begin
        t_fmt_request req;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (in_wait > 0) begin
                in_wait--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                i_action <= req.action;
                i_spec   <= req.spec;
                i_value  <= req.value;
                i_valid  <= 1'b1;
                in_wait = $urandom_range(0, in_max_gap);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stalls, one draw per character
    always @(negedge i_clk) begin
        if (!i_ready || out_taken) begin
            if (out_wait > 0) begin
                out_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                out_wait = $urandom_range(0, out_max_stall);
            end
        end
    end

    // monitor: predict on accepted requests, check each character transaction
    always @(posedge i_clk) begin
        t_text_char e;
        in_taken  <= i_rst_n && i_valid && o_ready;
        out_taken <= i_rst_n && o_valid && i_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_text(i_action, i_spec, i_value);
            end
            if (o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected character 0x%02h last %0d", $time,
                             o_char_out, o_last);
                end else begin
                    e = expected_chars.pop_front();
                    if (o_char_out !== e.ch) begin
                        mismatch_count++;
                        $display("%0t: char_out expected 0x%02h actual 0x%02h", $time,
                                 e.ch, o_char_out);
                    end
                    if (o_last !== e.last) begin
                        mismatch_count++;
                        $display("%0t: last expected %0d actual %0d", $time,
                                 e.last, o_last);
                    end
                end
            end
        end
    end

    task automatic add_request(input logic action, input logic [7:0] spec,
                               input logic [63:0] value);
        t_fmt_request req;
        req.action = action;
        req.spec = spec;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // argument with a mix of shapes: zero, small, full, negative, short, edges
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = 64'd0;
            1: v = 64'($urandom_range(0, 20));
            2: ;
            3: v[31] = 1'b1;
            4: v = v >> $urandom_range(0, 63);
            default: begin
                case ($urandom_range(0, 2))
                    0: v[31:0] = 32'h8000_0000;
                    1: v[31:0] = 32'h7fff_ffff;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        while (pending_requests.size() != 0 || i_valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // stimulus
    initial begin
        logic [7:0] known_specs [0:7];
        logic [7:0] spec;
        logic       action;
        int         roll;
        int         seg;
        int         produced;
        bit         is_known;

        known_specs[0] = CH_C;
        known_specs[1] = CH_D;
        known_specs[2] = CH_I;
        known_specs[3] = CH_U;
        known_specs[4] = CH_LX;
        known_specs[5] = CH_UX;
        known_specs[6] = CH_P;
        known_specs[7] = CH_PCT;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: literals, each conversion at its edges, unknown specifiers
        add_request(1'b0, 8'h00, 64'd0);
        add_request(1'b0, 8'hff, '1);
        add_request(1'b0, CH_D, 64'd5);
        add_request(1'b1, CH_C, 64'hffff_ffff_ffff_ff00);
        add_request(1'b1, CH_C, 64'h0000_0000_0000_00ff);
        add_request(1'b1, CH_D, 64'd0);
        add_request(1'b1, CH_D, 64'hffff_ffff_8000_0000);
        add_request(1'b1, CH_D, 64'h0000_0000_7fff_ffff);
        add_request(1'b1, CH_I, 64'h0000_0000_ffff_ffff);
        add_request(1'b1, CH_I, 64'h1234_5678_ffff_cfc7);
        add_request(1'b1, CH_U, 64'hffff_ffff_0000_0000);
        add_request(1'b1, CH_U, 64'h0000_0000_ffff_ffff);
        add_request(1'b1, CH_LX, 64'd0);
        add_request(1'b1, CH_LX, 64'hdead_beef_dead_beef);
        add_request(1'b1, CH_UX, 64'h0000_0000_ffff_ffff);
        add_request(1'b1, CH_UX, 64'h0000_0000_00ab_cdef);
        add_request(1'b1, CH_P, 64'd0);
        add_request(1'b1, CH_P, '1);
        add_request(1'b1, CH_P, 64'd1);
        add_request(1'b1, CH_P, 64'h0000_0001_0000_0000);
        add_request(1'b1, CH_PCT, '1);
        add_request(1'b1, SPEC_STRING, 64'd77);
        add_request(1'b1, 8'h00, 64'd3);
        add_request(1'b1, 8'hff, 64'd3);
        add_request(1'b1, CH_PCT, 64'd0);
        wait_idle();

        // random segments with different gap and stall limits
        for (seg = 0; seg < 4; seg++) begin
            in_max_gap    = (seg == 0 || seg == 2) ? 0 : 15;
            out_max_stall = (seg == 0 || seg == 3) ? 0 : 15;
            produced = 0;
            while (produced < RAND_ITEMS / 4) begin
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    action = 1'b0;
                    spec = 8'($urandom());
                    produced++;
                end else if (roll == 1) begin
                    action = 1'b1;
                    do begin
                        spec = 8'($urandom());
                        is_known = 1'b0;
                        for (int k = 0; k < 8; k++) begin
                            if (spec == known_specs[k]) is_known = 1'b1;
                        end
                    end while (is_known);
                    produced++;
                end else begin
                    action = 1'b1;
                    spec = known_specs[$urandom_range(0, 7)];
                    produced++;
                end
                add_request(action, spec, rand_value());
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("PASS integer_to_text_formatter_unit");
        end else begin
            $display("FAIL integer_to_text_formatter_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("FAIL integer_to_text_formatter_unit");
        $finish;
    end

endmodule
